>>> src/b64c_pkg.sv
// Shared types, constants and character mapping functions for the Base64 codec.
// Used by every module of the codec; depends on nothing else.
package b64c_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_input;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_t;

  // One group of work for the back end. For an encode job, count is the
  // number of data bytes in the group; for a decode job, the number of
  // bytes to emit.
  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  count;
    logic [23:0] bits;
    logic        last;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] sx;
  } dec_t;

  function automatic logic [7:0] enc_char(logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  function automatic dec_t dec_char(logic [7:0] c);
    dec_t r;
    r.ok = 1'b1;
    r.sx = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sx = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sx = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sx = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.sx = 6'd62;
    end else if (c == 8'h2F) begin
      r.sx = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> src/b64c_front.sv
// Front end of the Base64 codec: takes input transfers, gathers groups and
// classifies them into jobs for the back end. Depends on b64c_pkg.
module b64c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              in_valid,
  input  b64c_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push,
  output b64c_pkg::job_t    job,
  output logic              decode_mode
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [1:0]  pad_seen, pad_seen_next;
  logic        accept;

  logic [1:0]     n_enc;
  logic [23:0]    enc_bits;
  logic           is_pad;
  b64c_pkg::dec_t dc;
  logic           dec_err;
  logic [5:0]     sx;
  logic [1:0]     pad_inc;
  logic [23:0]    dec_bits;

  assign accept = in_valid && !q_full;

  always_comb begin
    n_enc = (group_count == 2'd3) ? 2'd3 : group_count + 2'd1;
    case (n_enc)
      2'd1:    enc_bits = {in_item.in_byte, 16'h0000};
      2'd2:    enc_bits = group_bits | {8'h00, in_item.in_byte, 8'h00};
      default: enc_bits = group_bits | {16'h0000, in_item.in_byte};
    endcase

    is_pad  = (in_item.in_byte == b64c_pkg::PadChar);
    dc      = b64c_pkg::dec_char(in_item.in_byte);
    dec_err = is_pad ? (group_count < 2'd2) : (!dc.ok || pad_seen != 2'd0);
    pad_inc = is_pad ? pad_seen + 2'd1 : pad_seen;
    sx      = is_pad ? 6'd0 : dc.sx;
    case (group_count)
      2'd0:    dec_bits = group_bits | {sx, 18'h0};
      2'd1:    dec_bits = group_bits | {6'h0, sx, 12'h0};
      2'd2:    dec_bits = group_bits | {12'h0, sx, 6'h0};
      default: dec_bits = group_bits | {18'h0, sx};
    endcase

    push             = 1'b0;
    job.kind         = b64c_pkg::JOB_ERR;
    job.count        = 2'd0;
    job.bits         = 24'h0;
    job.last         = in_item.in_last;
    group_bits_next  = 24'h0;
    group_count_next = 2'd0;
    pad_seen_next    = 2'd0;

    if (!decode_mode) begin
      if (n_enc < 2'd3 && !in_item.in_last) begin
        group_bits_next  = enc_bits;
        group_count_next = n_enc;
      end else begin
        push      = accept;
        job.kind  = b64c_pkg::JOB_ENC;
        job.count = n_enc;
        job.bits  = enc_bits;
      end
    end else if (dec_err) begin
      push = accept;
    end else if (group_count < 2'd3) begin
      if (in_item.in_last) begin
        // The message ends part way through a group.
        push = accept;
      end else begin
        group_bits_next  = dec_bits;
        group_count_next = group_count + 2'd1;
        pad_seen_next    = pad_inc;
      end
    end else begin
      push      = accept;
      job.kind  = b64c_pkg::JOB_DEC;
      job.count = 2'd3 - pad_inc;
      job.bits  = dec_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group_bits  <= 24'h0;
      group_count <= 2'd0;
      pad_seen    <= 2'd0;
    end else if (cfg_we) begin
      decode_mode <= cfg_data;
      group_bits  <= 24'h0;
      group_count <= 2'd0;
      pad_seen    <= 2'd0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_seen    <= pad_seen_next;
    end
  end

endmodule

>>> src/b64c_queue.sv
// Short job queue between the front and back ends of the Base64 codec.
// Depends on b64c_pkg for the job type.
module b64c_queue #(
  parameter int Depth = b64c_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output b64c_pkg::job_t head
);

  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  b64c_pkg::job_t      slots [Depth];
  logic [AddrW-1:0]    wr_ptr, rd_ptr;
  logic [CountW-1:0]   count;

  assign full      = (count == CountW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/b64c_back.sv
// Back end of the Base64 codec: expands each queued job into results, one
// per unstalled cycle, through an output register. Depends on b64c_pkg.
module b64c_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  b64c_pkg::job_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output b64c_pkg::out_item_t out_item
);

  logic [1:0]          idx;
  logic [1:0]          last_idx;
  logic                load;
  b64c_pkg::out_item_t res;
  logic [5:0]          sext;

  assign load = !out_valid || !out_stall;
  assign pop  = load && q_valid && (idx == last_idx);

  always_comb begin
    case (idx)
      2'd0:    sext = head.bits[23:18];
      2'd1:    sext = head.bits[17:12];
      2'd2:    sext = head.bits[11:6];
      default: sext = head.bits[5:0];
    endcase
    res.bad_input = 1'b0;
    res.out_byte  = 8'h00;
    unique case (head.kind)
      b64c_pkg::JOB_ENC: begin
        last_idx = 2'd3;
        if (idx > head.count) begin
          res.out_byte = b64c_pkg::PadChar;
        end else begin
          res.out_byte = b64c_pkg::enc_char(sext);
        end
      end
      b64c_pkg::JOB_DEC: begin
        last_idx = head.count - 2'd1;
        case (idx)
          2'd0:    res.out_byte = head.bits[23:16];
          2'd1:    res.out_byte = head.bits[15:8];
          default: res.out_byte = head.bits[7:0];
        endcase
      end
      default: begin
        last_idx      = 2'd0;
        res.bad_input = 1'b1;
      end
    endcase
    res.out_last = head.last && (idx == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        idx <= (idx == last_idx) ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

>>> src/base64_codec.sv
// Top level of the streaming Base64 codec (standard alphabet, '=' padding).
// Depends on b64c_pkg, b64c_front, b64c_queue and b64c_back.
//
//   Channel   Direction  Handshake           Payload
//   in        into       in_valid/in_stall   in_item  (in_byte, in_last)
//   out       out of     out_valid/out_stall out_item (out_byte, out_last, bad_input)
//   cfg       into       cfg_we              cfg_data (decode_mode)
//
// The front end takes one input transfer per cycle while the job queue has
// room, and the back end drives one result per cycle from its output
// register while out_stall is low. A group's first result passes the job
// queue and the output register after the group's last transfer. Sustained
// encode throughput, set by the single result port, is four characters per
// three input bytes; decode runs at one character per cycle with no output
// stall. Reset is synchronous and clears the mode, the group state, the
// queue and the output valid. in_stall is high exactly while the queue is
// full, so an output stall backs up through the queue to the input.
module base64_codec #(
  parameter int QueueDepth = b64c_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64c_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output b64c_pkg::out_item_t out_item
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  logic           decode_mode;
  b64c_pkg::job_t push_job;
  b64c_pkg::job_t head;

  assign in_stall = q_full;

  // The front end gathers bytes or characters into a group and hands a job
  // to the queue whenever a group closes or an error is found.
  b64c_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job),
    .decode_mode (decode_mode)
  );

  b64c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  // The back end turns each job into one to four result transfers.
  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // An error result never carries data.
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_input |-> out_item.out_byte == 8'h00)
    else $error("error result carries a data byte");

  // Encoding never reports bad input.
  a_enc_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && !decode_mode |-> !out_item.bad_input)
    else $error("error result while encoding");

  // A job is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // A job is only taken from the queue while one is held.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("job taken from empty queue");

endmodule
